// ===== sv/convex_hull_graham_scan_macros.svh =====
// assertion helpers for the hull block
`ifndef CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CHG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hull block check failed");
// next-cycle implication
`define CHG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hull block check failed");
`else
`define CHG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CHG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/chg_pkg.sv =====
`default_nettype none
package chg_pkg;

    // coordinate width and widest index the command word carries
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = 10;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] hull_x;
        logic signed [COORD_BITS-1:0] hull_y;
        logic                         hull_last;
        logic                         overflow;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    // multiplier stage operation
    typedef enum logic [1:0] {
        MUL_NONE  = 2'd0,
        MUL_CROSS = 2'd1,
        MUL_DB    = 2'd2,
        MUL_DC    = 2'd3
    } t_mul_op;

    typedef struct packed {
        logic                pwr;
        logic                prd;
        logic                prd_from_ir;
        logic [IDX_BITS-1:0] paddr;
        logic                iwr;
        logic [IDX_BITS-1:0] iaddr_w;
        logic [IDX_BITS-1:0] idata;
        logic                ird;
        logic [IDX_BITS-1:0] iaddr_r;
        logic                ld_v;
        logic                ld_a;
        logic                ld_b;
        logic                ld_c;
        logic                b_from_c;
        logic                psel_a;
        t_mul_op             mul_op;
        logic                out_ld;
        logic                out_last;
        logic                out_ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic [IDX_BITS-1:0] ir;
        logic                piv_less;
        logic                turn_neg;
        logic                turn_zero;
        logic                dist_lt;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== sv/chg_dpath.sv =====
`default_nettype none
module chg_dpath #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire chg_pkg::t_dp_cmd   i_cmd,
    input  wire chg_pkg::t_in_word  i_in_word,
    output chg_pkg::t_dp_sts        o_sts,
    output chg_pkg::t_out_word      o_out_word
);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int XW = chg_pkg::IDX_BITS;
    localparam int D  = chg_pkg::COORD_BITS + 1;
    localparam int PW = 2 * D;
    localparam int RW = PW + 1;

    chg_pkg::t_point    pmem [MAX_POINTS];
    logic [IW-1:0]      imem [MAX_POINTS];

    chg_pkg::t_point    r_pr, r_pv, r_a, r_b, r_c;
    logic [IW-1:0]      r_ir;
    logic signed [PW-1:0] r_m1, r_m2;
    chg_pkg::t_mul_op   r_tag;
    logic signed [RW-1:0] r_cr, r_db, r_dc;
    chg_pkg::t_out_word r_out;

    chg_pkg::t_point    p_org;
    logic [IW-1:0]      paddr_rd;
    logic signed [D-1:0] d_bpx, d_bpy, d_cpx, d_cpy, d_cbx, d_cby;
    logic signed [D-1:0] op_a1, op_b1, op_a2, op_b2;

    // point store: load port and one registered read port
    assign paddr_rd = i_cmd.prd_from_ir ? r_ir : i_cmd.paddr[IW-1:0];
    always_ff @(posedge i_clk) begin
        if (i_cmd.pwr) begin
            pmem[i_cmd.paddr[IW-1:0]] <= '{x: i_in_word.point_x, y: i_in_word.point_y};
        end
        if (i_cmd.prd) begin
            r_pr <= pmem[paddr_rd];
        end
    end

    // index list, shared by sort order, kept list and stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.iwr) begin
            imem[i_cmd.iaddr_w[IW-1:0]] <= i_cmd.idata[IW-1:0];
        end
        if (i_cmd.ird) begin
            r_ir <= imem[i_cmd.iaddr_r[IW-1:0]];
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_v) begin
            r_pv <= r_pr;
        end
        if (i_cmd.ld_a) begin
            r_a <= r_pr;
        end
        if (i_cmd.b_from_c) begin
            r_b <= r_c;
        end else if (i_cmd.ld_b) begin
            r_b <= r_pr;
        end
        if (i_cmd.ld_c) begin
            r_c <= r_pr;
        end
    end

    // differences against the origin point, and of c against b
    assign p_org = i_cmd.psel_a ? r_a : r_pv;
    assign d_bpx = D'(r_b.x) - D'(p_org.x);
    assign d_bpy = D'(r_b.y) - D'(p_org.y);
    assign d_cpx = D'(r_c.x) - D'(p_org.x);
    assign d_cpy = D'(r_c.y) - D'(p_org.y);
    assign d_cbx = D'(r_c.x) - D'(r_b.x);
    assign d_cby = D'(r_c.y) - D'(r_b.y);

    // multiplier operand select
    always_comb begin
        case (i_cmd.mul_op)
            chg_pkg::MUL_DB: begin
                op_a1 = d_bpx; op_b1 = d_bpx; op_a2 = d_bpy; op_b2 = d_bpy;
            end
            chg_pkg::MUL_DC: begin
                op_a1 = d_cpx; op_b1 = d_cpx; op_a2 = d_cpy; op_b2 = d_cpy;
            end
            default: begin
                op_a1 = d_bpy; op_b1 = d_cbx; op_a2 = d_bpx; op_b2 = d_cby;
            end
        endcase
    end

    // stage one: two products
    always_ff @(posedge i_clk) begin
        r_m1 <= op_a1 * op_b1;
        r_m2 <= op_a2 * op_b2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= chg_pkg::MUL_NONE;
        end else begin
            r_tag <= i_cmd.mul_op;
        end
    end

    // stage two: cross product or squared distance
    always_ff @(posedge i_clk) begin
        case (r_tag)
            chg_pkg::MUL_CROSS: r_cr <= RW'(r_m1) - RW'(r_m2);
            chg_pkg::MUL_DB:    r_db <= RW'(r_m1) + RW'(r_m2);
            chg_pkg::MUL_DC:    r_dc <= RW'(r_m1) + RW'(r_m2);
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out <= '{hull_x: r_pr.x, hull_y: r_pr.y,
                       hull_last: i_cmd.out_last, overflow: i_cmd.out_ovf};
        end
    end

    // status back to the controller
    assign o_sts.ir        = XW'(r_ir);
    assign o_sts.piv_less  = (r_pr.y < r_pv.y) || ((r_pr.y == r_pv.y) && (r_pr.x < r_pv.x));
    assign o_sts.turn_neg  = r_cr[RW-1];
    assign o_sts.turn_zero = (r_cr == '0);
    assign o_sts.dist_lt   = (r_db < r_dc);
    assign o_out_word      = r_out;

endmodule
`default_nettype wire

// ===== sv/chg_ctrl.sv =====
`default_nettype none
`include "convex_hull_graham_scan_macros.svh"
module chg_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_last,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire chg_pkg::t_dp_sts i_sts,
    output chg_pkg::t_dp_cmd      o_cmd
);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = chg_pkg::IDX_BITS;
    localparam int NS = 42;
    localparam logic [CW-1:0] ONE   = CW'(1);
    localparam logic [CW-1:0] TWO   = CW'(2);
    localparam logic [CW-1:0] THREE = CW'(3);
    localparam logic [CW-1:0] FULL  = CW'(MAX_POINTS);

    typedef enum logic [NS-1:0] {
        ST_IDLE  = NS'(1) << 0,  ST_PV0  = NS'(1) << 1,  ST_PV1  = NS'(1) << 2,
        ST_PVR   = NS'(1) << 3,  ST_PVC  = NS'(1) << 4,  ST_INIT = NS'(1) << 5,
        ST_SRI   = NS'(1) << 6,  ST_SRV  = NS'(1) << 7,  ST_SLB  = NS'(1) << 8,
        ST_SCHK  = NS'(1) << 9,  ST_SRW  = NS'(1) << 10, ST_SLC  = NS'(1) << 11,
        ST_SM0   = NS'(1) << 12, ST_SM1  = NS'(1) << 13, ST_SM2  = NS'(1) << 14,
        ST_SM3   = NS'(1) << 15, ST_SDEC = NS'(1) << 16, ST_SINS = NS'(1) << 17,
        ST_C0    = NS'(1) << 18, ST_C1   = NS'(1) << 19, ST_C2   = NS'(1) << 20,
        ST_CN    = NS'(1) << 21, ST_C3   = NS'(1) << 22, ST_C4   = NS'(1) << 23,
        ST_CM0   = NS'(1) << 24, ST_CM1  = NS'(1) << 25, ST_CDEC = NS'(1) << 26,
        ST_HRI   = NS'(1) << 27, ST_HRV  = NS'(1) << 28, ST_HLC  = NS'(1) << 29,
        ST_HCHK  = NS'(1) << 30, ST_HA   = NS'(1) << 31, ST_HA2  = NS'(1) << 32,
        ST_HA3   = NS'(1) << 33, ST_HM0  = NS'(1) << 34, ST_HM1  = NS'(1) << 35,
        ST_HDEC  = NS'(1) << 36, ST_ERI  = NS'(1) << 37, ST_ERP  = NS'(1) << 38,
        ST_EOUT  = NS'(1) << 39, ST_EWAIT = NS'(1) << 40, ST_FIN = NS'(1) << 41
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt, r_n, n_n, r_i, n_i, r_j, n_j, r_k, n_k;
    logic          r_drop, n_drop, r_ovalid, n_ovalid;
    logic [IW-1:0] r_m, n_m, r_v, n_v, r_w, n_w, r_bi, n_bi;

    logic [CW-1:0] jm1_w, jp1_w, km1_w, km2_w, ip1, kp1;
    logic [IW-1:0] i_ix, j_ix, k_ix, ir_ix;
    logic          full, precedes;

    assign jm1_w = r_j - ONE;
    assign jp1_w = r_j + ONE;
    assign km1_w = r_k - ONE;
    assign km2_w = r_k - TWO;
    assign ip1   = r_i + ONE;
    assign kp1   = r_k + ONE;
    assign i_ix  = r_i[IW-1:0];
    assign j_ix  = r_j[IW-1:0];
    assign k_ix  = r_k[IW-1:0];
    assign ir_ix = i_sts.ir[IW-1:0];
    assign full  = (r_cnt == FULL);
    assign precedes = i_sts.turn_zero ? i_sts.dist_lt : i_sts.turn_neg;

    // sequencer: load, pivot, sort, collinear pass, stack scan, emit
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_n = r_n; n_i = r_i; n_j = r_j; n_k = r_k;
        n_drop = r_drop; n_ovalid = r_ovalid;
        n_m = r_m; n_v = r_v; n_w = r_w; n_bi = r_bi;
        o_cmd = '0;
        o_cmd.mul_op = chg_pkg::MUL_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        o_cmd.pwr   = 1'b1;
                        o_cmd.paddr = XW'(r_cnt[IW-1:0]);
                        n_cnt       = r_cnt + ONE;
                    end
                    if (i_last) begin
                        n_n = full ? r_cnt : r_cnt + ONE;
                        n_i = '0;
                        n_j = ONE;
                        n_m = '0;
                        n_state = (n_n < THREE) ? ST_INIT : ST_PV0;
                    end
                end
            end
            // pivot search
            ST_PV0: begin
                o_cmd.prd = 1'b1;
                n_state = ST_PV1;
            end
            ST_PV1: begin
                o_cmd.ld_v = 1'b1;
                n_m = '0;
                n_i = ONE;
                n_state = ST_PVR;
            end
            ST_PVR: begin
                o_cmd.prd   = 1'b1;
                o_cmd.paddr = XW'(i_ix);
                n_state = ST_PVC;
            end
            ST_PVC: begin
                if (i_sts.piv_less) begin
                    o_cmd.ld_v = 1'b1;
                    n_m = i_ix;
                end
                n_i = ip1;
                if (ip1 == r_n) begin
                    n_i = '0;
                    n_j = ONE;
                    n_state = ST_INIT;
                end else begin
                    n_state = ST_PVR;
                end
            end
            // pivot first, others in arrival order
            ST_INIT: begin
                o_cmd.iwr     = 1'b1;
                o_cmd.iaddr_w = (i_ix == r_m) ? '0 : XW'(j_ix);
                o_cmd.idata   = XW'(i_ix);
                if (i_ix != r_m) begin
                    n_j = jp1_w;
                end
                n_i = ip1;
                if (ip1 == r_n) begin
                    if (r_n < THREE) begin
                        n_i = '0;
                        n_state = ST_ERI;
                    end else begin
                        n_i = TWO;
                        n_state = ST_SRI;
                    end
                end
            end
            // insertion sort by angle
            ST_SRI: begin
                o_cmd.ird     = 1'b1;
                o_cmd.iaddr_r = XW'(i_ix);
                n_state = ST_SRV;
            end
            ST_SRV: begin
                n_v = ir_ix;
                o_cmd.prd = 1'b1;
                o_cmd.prd_from_ir = 1'b1;
                n_j = r_i;
                n_state = ST_SLB;
            end
            ST_SLB: begin
                o_cmd.ld_b = 1'b1;
                n_state = ST_SCHK;
            end
            ST_SCHK: begin
                if (r_j > ONE) begin
                    o_cmd.ird     = 1'b1;
                    o_cmd.iaddr_r = XW'(jm1_w[IW-1:0]);
                    n_state = ST_SRW;
                end else begin
                    n_state = ST_SINS;
                end
            end
            ST_SRW: begin
                n_w = ir_ix;
                o_cmd.prd = 1'b1;
                o_cmd.prd_from_ir = 1'b1;
                n_state = ST_SLC;
            end
            ST_SLC: begin
                o_cmd.ld_c = 1'b1;
                n_state = ST_SM0;
            end
            ST_SM0: begin
                o_cmd.mul_op = chg_pkg::MUL_CROSS;
                n_state = ST_SM1;
            end
            ST_SM1: begin
                o_cmd.mul_op = chg_pkg::MUL_DB;
                n_state = ST_SM2;
            end
            ST_SM2: begin
                o_cmd.mul_op = chg_pkg::MUL_DC;
                n_state = ST_SM3;
            end
            ST_SM3: begin
                n_state = ST_SDEC;
            end
            ST_SDEC: begin
                if (precedes) begin
                    o_cmd.iwr     = 1'b1;
                    o_cmd.iaddr_w = XW'(j_ix);
                    o_cmd.idata   = XW'(r_w);
                    n_j = jm1_w;
                    n_state = ST_SCHK;
                end else begin
                    n_state = ST_SINS;
                end
            end
            ST_SINS: begin
                o_cmd.iwr     = 1'b1;
                o_cmd.iaddr_w = XW'(j_ix);
                o_cmd.idata   = XW'(r_v);
                n_i = ip1;
                if (ip1 == r_n) begin
                    n_j = ONE;
                    n_k = ONE;
                    n_state = ST_C0;
                end else begin
                    n_state = ST_SRI;
                end
            end
            // keep the farthest of each collinear run
            ST_C0: begin
                o_cmd.ird     = 1'b1;
                o_cmd.iaddr_r = XW'(j_ix);
                n_state = ST_C1;
            end
            ST_C1: begin
                n_bi = ir_ix;
                o_cmd.prd = 1'b1;
                o_cmd.prd_from_ir = 1'b1;
                n_state = ST_C2;
            end
            ST_C2: begin
                o_cmd.ld_b = 1'b1;
                n_state = ST_CN;
            end
            ST_CN: begin
                if (jp1_w == r_n) begin
                    o_cmd.iwr     = 1'b1;
                    o_cmd.iaddr_w = XW'(k_ix);
                    o_cmd.idata   = XW'(r_bi);
                    n_n = kp1;
                    // three or fewer kept points go out as they stand
                    if (kp1 <= THREE) begin
                        n_i = '0;
                        n_state = ST_ERI;
                    end else begin
                        n_i = THREE;
                        n_k = THREE;
                        n_state = ST_HRI;
                    end
                end else begin
                    o_cmd.ird     = 1'b1;
                    o_cmd.iaddr_r = XW'(jp1_w[IW-1:0]);
                    n_state = ST_C3;
                end
            end
            ST_C3: begin
                n_w = ir_ix;
                o_cmd.prd = 1'b1;
                o_cmd.prd_from_ir = 1'b1;
                n_state = ST_C4;
            end
            ST_C4: begin
                o_cmd.ld_c = 1'b1;
                n_state = ST_CM0;
            end
            ST_CM0: begin
                o_cmd.mul_op = chg_pkg::MUL_CROSS;
                n_state = ST_CM1;
            end
            ST_CM1: begin
                n_state = ST_CDEC;
            end
            ST_CDEC: begin
                if (!i_sts.turn_zero) begin
                    o_cmd.iwr     = 1'b1;
                    o_cmd.iaddr_w = XW'(k_ix);
                    o_cmd.idata   = XW'(r_bi);
                    n_k = kp1;
                end
                o_cmd.b_from_c = 1'b1;
                n_bi = r_w;
                n_j = jp1_w;
                n_state = ST_CN;
            end
            // stack scan, stack kept in place in the index list
            ST_HRI: begin
                o_cmd.ird     = 1'b1;
                o_cmd.iaddr_r = XW'(i_ix);
                n_state = ST_HRV;
            end
            ST_HRV: begin
                n_v = ir_ix;
                o_cmd.prd = 1'b1;
                o_cmd.prd_from_ir = 1'b1;
                n_state = ST_HLC;
            end
            ST_HLC: begin
                o_cmd.ld_c = 1'b1;
                n_state = ST_HCHK;
            end
            ST_HCHK: begin
                if (r_k > ONE) begin
                    o_cmd.ird     = 1'b1;
                    o_cmd.iaddr_r = XW'(km2_w[IW-1:0]);
                    n_state = ST_HA;
                end else begin
                    o_cmd.iwr     = 1'b1;
                    o_cmd.iaddr_w = XW'(k_ix);
                    o_cmd.idata   = XW'(r_v);
                    n_k = kp1;
                    n_i = ip1;
                    if (ip1 == r_n) begin
                        n_n = kp1;
                        n_i = '0;
                        n_state = ST_ERI;
                    end else begin
                        n_state = ST_HRI;
                    end
                end
            end
            ST_HA: begin
                o_cmd.prd = 1'b1;
                o_cmd.prd_from_ir = 1'b1;
                o_cmd.ird     = 1'b1;
                o_cmd.iaddr_r = XW'(km1_w[IW-1:0]);
                n_state = ST_HA2;
            end
            ST_HA2: begin
                o_cmd.ld_a = 1'b1;
                o_cmd.prd = 1'b1;
                o_cmd.prd_from_ir = 1'b1;
                n_state = ST_HA3;
            end
            ST_HA3: begin
                o_cmd.ld_b = 1'b1;
                n_state = ST_HM0;
            end
            ST_HM0: begin
                o_cmd.psel_a = 1'b1;
                o_cmd.mul_op = chg_pkg::MUL_CROSS;
                n_state = ST_HM1;
            end
            ST_HM1: begin
                n_state = ST_HDEC;
            end
            ST_HDEC: begin
                if (i_sts.turn_neg) begin
                    o_cmd.iwr     = 1'b1;
                    o_cmd.iaddr_w = XW'(k_ix);
                    o_cmd.idata   = XW'(r_v);
                    n_k = kp1;
                    n_i = ip1;
                    if (ip1 == r_n) begin
                        n_n = kp1;
                        n_i = '0;
                        n_state = ST_ERI;
                    end else begin
                        n_state = ST_HRI;
                    end
                end else begin
                    n_k = km1_w;
                    n_state = ST_HCHK;
                end
            end
            // emit the listed points
            ST_ERI: begin
                o_cmd.ird     = 1'b1;
                o_cmd.iaddr_r = XW'(i_ix);
                n_state = ST_ERP;
            end
            ST_ERP: begin
                o_cmd.prd = 1'b1;
                o_cmd.prd_from_ir = 1'b1;
                n_state = ST_EOUT;
            end
            ST_EOUT: begin
                o_cmd.out_ld   = 1'b1;
                o_cmd.out_last = (ip1 == r_n);
                o_cmd.out_ovf  = r_drop;
                n_ovalid = 1'b1;
                n_state = ST_EWAIT;
            end
            ST_EWAIT: begin
                if (!i_out_stall) begin
                    n_ovalid = 1'b0;
                    n_i = ip1;
                    n_state = (ip1 == r_n) ? ST_FIN : ST_ERI;
                end
            end
            ST_FIN: begin
                n_cnt  = '0;
                n_drop = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_m      <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
            r_n      <= n_n;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_m      <= n_m;
        end
    end

    // held indices
    always_ff @(posedge i_clk) begin
        r_v  <= n_v;
        r_w  <= n_w;
        r_bi <= n_bi;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;

    `CHG_ASSERT_IMP(a_ovalid_wait, i_clk, i_rst_n, r_ovalid, r_state == ST_EWAIT)
    `CHG_ASSERT_IMP(a_scan_depth, i_clk, i_rst_n, r_state == ST_HDEC, r_k >= TWO)
    `CHG_ASSERT_IMP(a_emit_range, i_clk, i_rst_n, r_state == ST_EOUT, r_i < r_n)
    `CHG_ASSERT_NXT(a_fin_clear, i_clk, i_rst_n, r_state == ST_FIN, (r_cnt == '0) && (r_state == ST_IDLE))

endmodule
`default_nettype wire

// ===== sv/convex_hull_graham_scan.sv =====
// points load one per cycle while o_in_stall is low; the word with last_point starts the hull run
// a run does an insertion sort by angle (up to n*n/2 angular comparisons), a collinear pass,
// a stack scan with a turn test per step, and then emits each hull vertex
// run length is set by the single point memory read port and the 2-stage cross unit
// no new point is taken until the last hull word of a run has been taken
// synchronous active-low reset clears control state; stores need no clearing pass
`default_nettype none
module convex_hull_graham_scan #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire chg_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output chg_pkg::t_out_word      o_out_word
);
    chg_pkg::t_dp_cmd dp_cmd;
    chg_pkg::t_dp_sts dp_sts;

    // sequencer
    chg_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_in_word.last_point),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // storage and arithmetic
    chg_dpath #(.MAX_POINTS(MAX_POINTS)) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_in_word  (i_in_word),
        .o_sts      (dp_sts),
        .o_out_word (o_out_word)
    );

endmodule
`default_nettype wire
